>>> rtl/pcf_pkg.sv
// Package for the printf conversion formatter: conversion kind codes,
// ASCII constants and the command/status structs between controller and datapath.
// No dependencies.
package pcf_pkg;

   localparam logic [2:0] KIND_PCT  = 3'd0;
   localparam logic [2:0] KIND_SDEC = 3'd1;
   localparam logic [2:0] KIND_UDEC = 3'd2;
   localparam logic [2:0] KIND_HEXL = 3'd3;
   localparam logic [2:0] KIND_HEXU = 3'd4;
   localparam logic [2:0] KIND_CHR  = 3'd5;
   localparam logic [2:0] KIND_PTR  = 3'd6;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_X       = 8'h78;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;

   localparam int DIG_N = 20;

   typedef struct packed {
      logic load;
      logic conv_step;
      logic scan_step;
      logic emit_step;
   } pcf_cmd_type;

   typedef struct packed {
      logic in_dec;
      logic conv_last;
      logic scan_done;
      logic total_zero;
      logic out_free;
      logic emit_last;
   } pcf_stat_type;

endpackage

>>> rtl/pcf_if.sv
// Valid/ready channel interfaces for the printf conversion formatter.
// pcf_req_if carries one parsed conversion, pcf_rsp_if one output character.
interface pcf_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic        wide;
   logic [63:0] value;
   logic [5:0]  width;
   logic        left_align;
   logic        zero_pad;

   modport source (output valid, kind, wide, value, width, left_align, zero_pad,
                   input ready);
   modport sink   (input valid, kind, wide, value, width, left_align, zero_pad,
                   output ready);
endinterface

interface pcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, character, last, input ready);
   modport sink   (input valid, character, last, output ready);
endinterface

>>> rtl/pcf_ctrl.sv
// Controller state machine of the printf conversion formatter.
// Depends on pcf_pkg for the command and status structs.
module pcf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  pcf_pkg::pcf_stat_type stat,
   input  logic                  req_valid,
   output logic                  req_ready,
   output pcf_pkg::pcf_cmd_type  cmd
);
   import pcf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CONV = 4'b0010,
      S_SCAN = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.in_dec ? S_CONV : S_SCAN;
            end
         end
         S_CONV: begin
            cmd.conv_step = 1'b1;
            if (stat.conv_last) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = stat.total_zero ? S_IDLE : S_EMIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_step = 1'b1;
               if (stat.emit_last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> rtl/pcf_dp.sv
// Datapath of the printf conversion formatter: operand capture, shift-add-3
// binary to BCD conversion, leading zero scan, character select and output register.
// Depends on pcf_pkg.
module pcf_dp #(
   parameter int WIDTH_MAX = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pcf_pkg::pcf_cmd_type  cmd,
   output pcf_pkg::pcf_stat_type stat,
   input  logic [2:0]            req_kind,
   input  logic                  req_wide,
   input  logic [63:0]           req_value,
   input  logic [5:0]            req_width,
   input  logic                  req_left_align,
   input  logic                  req_zero_pad,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_character,
   output logic                  rsp_last
);
   import pcf_pkg::*;

   localparam logic [5:0] WMAX = 6'(WIDTH_MAX);
   localparam int         DW   = 4 * DIG_N;

   logic [2:0]    kind_ff, kind_in;
   logic          neg_ff, neg_in;
   logic [5:0]    wcl_ff, wcl_in;
   logic          left_ff, left_in;
   logic          zpad_ff, zpad_in;
   logic [7:0]    chr_ff, chr_in;
   logic [63:0]   mag_ff, mag_in;
   logic [DW-1:0] dig_ff, dig_in;
   logic [4:0]    ndig_ff, ndig_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [5:0]    pos_ff, pos_in;
   logic          rvalid_ff, rvalid_in;
   logic [7:0]    ochr_ff, ochr_in;
   logic          olast_ff, olast_in;

   logic [63:0]   sel_v, neg_v, mag_w, hex_w;
   logic          neg_w, in_dec;
   logic [DW-1:0] dab;
   logic [3:0]    top;
   logic [7:0]    dch;
   logic          has_dig;
   logic [1:0]    plen;
   logic [5:0]    tlen, pad, total, start, tpos;
   logic [7:0]    chr_sel;
   logic          is_dig;

   assign sel_v  = req_wide ? req_value : {32'b0, req_value[31:0]};
   assign neg_w  = (req_kind == KIND_SDEC) && (req_wide ? req_value[63] : req_value[31]);
   assign neg_v  = 64'(~sel_v + 64'd1);
   assign mag_w  = neg_w ? (req_wide ? neg_v : {32'b0, neg_v[31:0]}) : sel_v;
   assign hex_w  = (req_kind == KIND_PTR) ? req_value : sel_v;
   assign in_dec = (req_kind == KIND_SDEC) || (req_kind == KIND_UDEC);

   always_comb begin
      for (int i = 0; i < DIG_N; i++) begin
         dab[4*i +: 4] = (dig_ff[4*i +: 4] >= 4'd5) ? 4'(dig_ff[4*i +: 4] + 4'd3)
                                                    : dig_ff[4*i +: 4];
      end
   end

   assign top = dig_ff[DW-1 -: 4];
   assign dch = (top < 4'd10) ? 8'(CH_ZERO + {4'b0, top})
              : 8'(((kind_ff == KIND_HEXU) ? CH_UPPER_A : CH_LOWER_A) + {4'b0, top} - 8'd10);

   always_comb begin
      has_dig = 1'b0;
      plen    = 2'd0;
      case (kind_ff)
         KIND_PCT:  plen = 2'd1;
         KIND_SDEC: begin has_dig = 1'b1; plen = neg_ff ? 2'd1 : 2'd0; end
         KIND_UDEC: has_dig = 1'b1;
         KIND_HEXL: has_dig = 1'b1;
         KIND_HEXU: has_dig = 1'b1;
         KIND_CHR:  plen = 2'd1;
         KIND_PTR:  begin has_dig = 1'b1; plen = 2'd2; end
         default:   plen = 2'd0;
      endcase
   end

   assign tlen  = 6'({4'b0, plen} + (has_dig ? {1'b0, ndig_ff} : 6'd0));
   assign pad   = (wcl_ff > tlen) ? 6'(wcl_ff - tlen) : 6'd0;
   assign total = 6'(tlen + pad);
   assign start = left_ff ? 6'd0 : pad;
   assign tpos  = 6'(pos_ff - start);

   always_comb begin
      chr_sel = CH_SPACE;
      is_dig  = 1'b0;
      if (pos_ff < start) begin
         chr_sel = zpad_ff ? CH_ZERO : CH_SPACE;
      end else if (tpos >= tlen) begin
         chr_sel = CH_SPACE;
      end else if (tpos < {4'b0, plen}) begin
         case (kind_ff)
            KIND_PCT:  chr_sel = CH_PERCENT;
            KIND_SDEC: chr_sel = CH_MINUS;
            KIND_CHR:  chr_sel = chr_ff;
            KIND_PTR:  chr_sel = tpos[0] ? CH_X : CH_ZERO;
            default:   chr_sel = CH_SPACE;
         endcase
      end else begin
         chr_sel = dch;
         is_dig  = 1'b1;
      end
   end

   assign stat.in_dec     = in_dec;
   assign stat.conv_last  = &cnt_ff;
   assign stat.scan_done  = (ndig_ff == 5'd1) || (top != 4'd0);
   assign stat.total_zero = (total == 6'd0);
   assign stat.out_free   = !rvalid_ff || rsp_ready;
   assign stat.emit_last  = (pos_ff == 6'(total - 6'd1));

   always_comb begin
      kind_in   = kind_ff;
      neg_in    = neg_ff;
      wcl_in    = wcl_ff;
      left_in   = left_ff;
      zpad_in   = zpad_ff;
      chr_in    = chr_ff;
      mag_in    = mag_ff;
      dig_in    = dig_ff;
      ndig_in   = ndig_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      ochr_in   = ochr_ff;
      olast_in  = olast_ff;
      rvalid_in = rvalid_ff && !rsp_ready;
      if (cmd.load) begin
         kind_in = req_kind;
         neg_in  = neg_w;
         wcl_in  = (req_width > WMAX) ? WMAX : req_width;
         left_in = req_left_align;
         zpad_in = req_zero_pad && !req_left_align;
         chr_in  = req_value[7:0];
         mag_in  = mag_w;
         dig_in  = in_dec ? '0 : {{(DW-64){1'b0}}, hex_w};
         ndig_in = 5'(DIG_N);
         cnt_in  = 6'd0;
         pos_in  = 6'd0;
      end
      if (cmd.conv_step) begin
         dig_in = {dab[DW-2:0], mag_ff[63]};
         mag_in = {mag_ff[62:0], 1'b0};
         cnt_in = 6'(cnt_ff + 6'd1);
      end
      if (cmd.scan_step) begin
         dig_in  = {dig_ff[DW-5:0], 4'b0};
         ndig_in = 5'(ndig_ff - 5'd1);
      end
      if (cmd.emit_step) begin
         ochr_in   = chr_sel;
         olast_in  = stat.emit_last;
         rvalid_in = 1'b1;
         pos_in    = 6'(pos_ff + 6'd1);
         if (is_dig) dig_in = {dig_ff[DW-5:0], 4'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rvalid_ff <= 1'b0;
      else       rvalid_ff <= rvalid_in;
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      neg_ff   <= neg_in;
      wcl_ff   <= wcl_in;
      left_ff  <= left_in;
      zpad_ff  <= zpad_in;
      chr_ff   <= chr_in;
      mag_ff   <= mag_in;
      dig_ff   <= dig_in;
      ndig_ff  <= ndig_in;
      cnt_ff   <= cnt_in;
      pos_ff   <= pos_in;
      ochr_ff  <= ochr_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid     = rvalid_ff;
   assign rsp_character = ochr_ff;
   assign rsp_last      = olast_ff;

endmodule

>>> rtl/printf_conversion_formatter_top.sv
// printf conversion formatter, top level.
// Takes one parsed conversion on req_chan and sends its ASCII characters on rsp_chan.
// Depends on pcf_pkg, pcf_if, pcf_ctrl and pcf_dp.
//
// Usage:
//   req_chan transfers one conversion (kind, wide, value, width, left_align,
//   zero_pad) when valid and ready are high; rsp_chan transfers one character
//   per cycle while the receiver is ready, last marking the field's final character.
//   One conversion is in work at a time; ready is high only while idle.
//   Steps: capture, shift-add-3 BCD conversion for decimal kinds only, a
//   leading zero scan, then one character per cycle into the output
//   register while it is free.
//   The next conversion is taken while the final character still waits.
//   An unused kind with width zero produces no characters.
//   Reset (synchronous) returns the controller to idle and drops any pending
//   character. When the receiver stalls, emission holds and resumes unchanged.
module printf_conversion_formatter_top #(
   parameter int WIDTH_MAX = 63
) (
   input logic        clock,
   input logic        reset,
   pcf_req_if.sink    req_chan,
   pcf_rsp_if.source  rsp_chan
);
   import pcf_pkg::*;

   pcf_cmd_type  cmd;
   pcf_stat_type stat;
   logic         req_ready;

   pcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   pcf_dp #(
      .WIDTH_MAX (WIDTH_MAX)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_chan.kind),
      .req_wide       (req_chan.wide),
      .req_value      (req_chan.value),
      .req_width      (req_chan.width),
      .req_left_align (req_chan.left_align),
      .req_zero_pad   (req_chan.zero_pad),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_character  (rsp_chan.character),
      .rsp_last       (rsp_chan.last)
   );

   assign req_chan.ready = req_ready;

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input ready after a transfer");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_step |-> stat.out_free)
      else $error("character register overwritten before transfer");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_step && stat.emit_last) |=> req_chan.ready)
      else $error("controller not idle after final character");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.conv_step, cmd.scan_step, cmd.emit_step}))
      else $error("conflicting datapath commands");

endmodule
